>>> src/gecn_pkg.sv
// Shared types and constants for the grid edge neighbor counter.
// No dependencies; used by the interfaces, the row line and the top level.
`default_nettype none

package gecn_pkg;

  localparam int CfgW            = 7;
  localparam int CountW          = 13;
  localparam int MaxWidthDefault = 64;
  localparam int GridWidthRst    = 64;

  localparam logic [CountW-1:0] CountMax = {CountW{1'b1}};

  // One stored cell of the previous row: its value and its already-counted flag.
  typedef struct packed {
    logic val;
    logic cnt;
  } entry_t;

  // Push request from the control into the row line.
  typedef struct packed {
    logic   shift;
    logic   mark;
    entry_t entry;
  } row_push_t;

endpackage

`default_nettype wire

>>> src/gecn_if.sv
// Valid/ready channel interfaces for the grid edge neighbor counter.
// Depends on gecn_pkg for payload widths.
`default_nettype none

interface gecn_cell_if;
  logic valid;
  logic ready;
  logic cell_value;
  modport source (output valid, output cell_value, input ready);
  modport sink   (input valid, input cell_value, output ready);
endinterface

interface gecn_count_if;
  logic                        valid;
  logic                        ready;
  logic [gecn_pkg::CountW-1:0] edge_count;
  modport source (output valid, output edge_count, input ready);
  modport sink   (input valid, input edge_count, output ready);
endinterface

interface gecn_cfg_if;
  logic                      valid;
  logic                      ready;
  logic [gecn_pkg::CfgW-1:0] grid_width;
  modport source (output valid, output grid_width, input ready);
  modport sink   (input valid, input grid_width, output ready);
endinterface

`default_nettype wire

>>> src/grid_edge_neighbor_count_top.sv
// Top level of the grid edge neighbor counter: position, count and output register.
// Depends on gecn_pkg, gecn_if interfaces and gecn_row.
//
//   channel   dir   payload              handshake
//   cell_i    in    cell_value [0:0]     valid/ready
//   count_o   out   edge_count [12:0]    valid/ready
//   cfg_i     in    grid_width [6:0]     valid/ready (always ready)
//
// One cell per cycle unless stalled; the row line shifts once per accepted cell and
// feeds the cell above. The result is registered the cycle after the last cell of a grid.
// Input stalls only while a result sits in the output register and is not taken.
// Reset clears position, count and output valid; width returns to 64 (or MAX_WIDTH).
`default_nettype none

module grid_edge_neighbor_count_top #(
  parameter int MAX_WIDTH = gecn_pkg::MaxWidthDefault
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  gecn_cell_if.sink        cell_i,
  gecn_count_if.source     count_o,
  gecn_cfg_if.sink         cfg_i
);

  localparam int IW = $clog2(MAX_WIDTH);
  localparam int CW = gecn_pkg::CountW;
  localparam logic [gecn_pkg::CfgW-1:0] CfgRst = gecn_pkg::CfgW'(
    (MAX_WIDTH < gecn_pkg::GridWidthRst) ? MAX_WIDTH : gecn_pkg::GridWidthRst);
  localparam logic [8:0] MaxW9 = 9'(MAX_WIDTH);

  logic [gecn_pkg::CfgW-1:0] cfg_q;
  logic [IW-1:0]             col_q, col_d;
  logic [IW-1:0]             row_q, row_d;
  logic                      left_val_q, left_val_d;
  logic                      left_cnt_q, left_cnt_d;
  logic [CW-1:0]             cnt_q, cnt_d;
  logic                      out_valid_q;
  logic [CW-1:0]             out_data_q;

  logic [8:0]          w9;
  logic [IW-1:0]       wlast;
  logic                acc;
  logic                has_up, has_left;
  gecn_pkg::entry_t    tap, up;
  logic                v, cur_cnt, up_new, left_new;
  logic [1:0]          inc;
  logic [CW:0]         sum;
  logic [CW-1:0]       cnt_sat;
  logic                row_end, grid_end;
  gecn_pkg::row_push_t push;

  // effective width: 0 acts as 1, above MAX_WIDTH acts as MAX_WIDTH
  always_comb begin
    w9 = 9'(cfg_q);
    if (w9 == 9'd0) begin
      wlast = '0;
    end else if (w9 > MaxW9) begin
      wlast = IW'(MAX_WIDTH - 1);
    end else begin
      wlast = IW'(w9 - 9'd1);
    end
  end

  assign cfg_i.ready  = 1'b1;
  assign cell_i.ready = !out_valid_q || count_o.ready;
  assign acc          = cell_i.valid && cell_i.ready;

  assign v        = cell_i.cell_value;
  assign has_up   = (row_q != '0);
  assign has_left = (col_q != '0);
  assign up       = has_up ? tap : '0;

  always_comb begin
    cur_cnt  = 1'b0;
    up_new   = 1'b0;
    left_new = 1'b0;
    if (!v) begin
      cur_cnt = up.val || (has_left && left_val_q);
    end else begin
      up_new   = has_up && !up.val && !up.cnt;
      left_new = has_left && !left_val_q && !left_cnt_q;
    end
    inc = {1'b0, cur_cnt} + {1'b0, up_new} + {1'b0, left_new};
  end

  assign sum     = {1'b0, cnt_q} + (CW+1)'(inc);
  assign cnt_sat = sum[CW] ? gecn_pkg::CountMax : sum[CW-1:0];

  assign row_end  = (col_q >= wlast);
  assign grid_end = row_end && (row_q >= wlast);

  always_comb begin
    col_d      = col_q + IW'(1);
    row_d      = row_q;
    cnt_d      = cnt_sat;
    left_val_d = v;
    left_cnt_d = cur_cnt;
    if (row_end) begin
      col_d = '0;
      if (grid_end) begin
        row_d      = '0;
        cnt_d      = '0;
        left_val_d = 1'b0;
        left_cnt_d = 1'b0;
      end else begin
        row_d = row_q + IW'(1);
      end
    end
  end

  assign push.shift     = acc;
  assign push.mark      = left_new;
  assign push.entry.val = v;
  assign push.entry.cnt = cur_cnt;

  gecn_row #(
    .MAX_WIDTH (MAX_WIDTH)
  ) u_row (
    .clk_i   (clk_i),
    .wlast_i (wlast),
    .push_i  (push),
    .tap_o   (tap)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q       <= CfgRst;
      col_q       <= '0;
      row_q       <= '0;
      left_val_q  <= 1'b0;
      left_cnt_q  <= 1'b0;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_i.valid) begin
        cfg_q <= cfg_i.grid_width;
      end
      if (acc) begin
        col_q      <= col_d;
        row_q      <= row_d;
        left_val_q <= left_val_d;
        left_cnt_q <= left_cnt_d;
        cnt_q      <= cnt_d;
      end
      if (acc && grid_end) begin
        out_valid_q <= 1'b1;
      end else if (count_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (acc && grid_end) begin
      out_data_q <= cnt_sat;
    end
  end

  assign count_o.valid      = out_valid_q;
  assign count_o.edge_count = out_data_q;

endmodule

`default_nettype wire

>>> src/gecn_cell.sv
// One cell of the row delay line: holds a single previous-row entry.
// Depends on gecn_pkg (entry_t).
`default_nettype none

module gecn_cell (
  input  wire logic             clk_i,
  input  wire logic             shift_i,
  input  wire logic             load_i,
  input  wire logic             mark_i,
  input  wire gecn_pkg::entry_t push_i,
  input  wire gecn_pkg::entry_t nbr_i,
  output gecn_pkg::entry_t      q_o
);

  gecn_pkg::entry_t ent_q, ent_d;

  always_comb begin
    if (load_i) begin
      ent_d = push_i;
    end else begin
      ent_d.val = nbr_i.val;
      ent_d.cnt = nbr_i.cnt | mark_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (shift_i) begin
      ent_q <= ent_d;
    end
  end

  assign q_o = ent_q;

endmodule

`default_nettype wire

>>> src/gecn_row.sv
// Variable-length row delay line built from a chain of gecn_cell.
// New entries enter at the cell of the last column; the output tap is cell 0.
// Depends on gecn_pkg and gecn_cell.
`default_nettype none

module gecn_row #(
  parameter int MAX_WIDTH = gecn_pkg::MaxWidthDefault,
  localparam int IW = $clog2(MAX_WIDTH)
) (
  input  wire logic                clk_i,
  input  wire logic [IW-1:0]       wlast_i,
  input  wire gecn_pkg::row_push_t push_i,
  output gecn_pkg::entry_t         tap_o
);

  gecn_pkg::entry_t cell_q [MAX_WIDTH];

  for (genvar k = 0; k < MAX_WIDTH; k++) begin : g_cell
    gecn_pkg::entry_t nbr;
    logic             load;
    logic             mark;

    if (k == MAX_WIDTH - 1) begin : g_end
      assign nbr = '0;
    end else begin : g_mid
      assign nbr = cell_q[k+1];
    end

    assign load = (wlast_i == IW'(k));
    // newest entry moves out of the insert cell: apply the late counted flag
    assign mark = push_i.mark && ({1'b0, wlast_i} == (IW+1)'(k + 1));

    gecn_cell u_cell (
      .clk_i   (clk_i),
      .shift_i (push_i.shift),
      .load_i  (load),
      .mark_i  (mark),
      .push_i  (push_i.entry),
      .nbr_i   (nbr),
      .q_o     (cell_q[k])
    );
  end

  assign tap_o = cell_q[0];

endmodule

`default_nettype wire
